FILE: design/arp_host_table_conflict_detector_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ARP_HOST_TABLE_CONFLICT_DETECTOR_MACROS_SVH
`define ARP_HOST_TABLE_CONFLICT_DETECTOR_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define AHT_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("aht check failed: same-cycle implication");

// Next-cycle implication, off while reset is asserted.
`define AHT_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("aht check failed: next-cycle implication");

// Next-cycle implication that is also checked through reset.
`define AHT_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("aht check failed: reset behavior");

`endif

FILE: design/aht_pkg.sv
`default_nettype none
package aht_pkg;

  localparam int TABLE_DEPTH   = 32;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_INDEX_W = 5;
  localparam int HOSTS_KNOWN_W = 6;
  localparam int TYPE_W        = 16;
  localparam int MAC_W         = 48;
  localparam int IP_W          = 32;
  localparam int PADDR_W       = 2;
  localparam int PDATA_W       = 32;

  localparam logic [TYPE_W-1:0]  ARP_TYPE_RESET     = 16'h0806;
  localparam logic [PADDR_W-1:0] REG_ARP_FRAME_TYPE = 2'd0;

  typedef enum logic [2:0] {
    EV_CONFLICT = 3'd0,
    EV_UPDATED  = 3'd1,
    EV_KNOWN    = 3'd2,
    EV_ADDED    = 3'd3,
    EV_FULL     = 3'd4,
    EV_IGNORED  = 3'd5
  } event_kind_t;

  typedef struct packed {
    logic [TYPE_W-1:0] frame_type;
    logic [MAC_W-1:0]  sender_mac;
    logic [IP_W-1:0]   sender_ip;
  } in_word_t;

  typedef struct packed {
    event_kind_t              event_kind;
    logic [MAC_W-1:0]         event_mac;
    logic [IP_W-1:0]          event_ip;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [HOSTS_KNOWN_W-1:0] hosts_known;
    logic                     last_event;
  } out_word_t;

  // Classified frame handed from the front end to the table engine.
  typedef struct packed {
    logic             is_arp;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FIND,
    BK_EMIT,
    BK_CLOSE
  } back_state_t;

endpackage
`default_nettype wire

FILE: design/aht_front.sv
`default_nettype none
module aht_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  aht_pkg::in_word_t                  in_word,
  input  logic [aht_pkg::TYPE_W-1:0]         arp_frame_type,
  output logic                               cmd_valid,
  output aht_pkg::cmd_t                      cmd,
  input  logic                               cmd_take
);

  aht_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          wr_en;
  logic          rd_en;
  aht_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.is_arp = (in_word.frame_type == arp_frame_type);
    cmd_in.mac    = in_word.sender_mac;
    cmd_in.ip     = in_word.sender_ip;
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign wr_en     = push && !full;
  assign rd_en     = cmd_take && cmd_valid;
  assign cmd       = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

FILE: design/aht_back.sv
`default_nettype none
module aht_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  aht_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               res_valid,
  output aht_pkg::out_word_t res,
  input  logic               res_ready
);

  localparam int IDX_W = aht_pkg::IDX_W;
  localparam int CNT_W = aht_pkg::CNT_W;

  logic [aht_pkg::MAC_W-1:0] mac_mem [aht_pkg::TABLE_DEPTH];
  logic [aht_pkg::IP_W-1:0]  ip_mem  [aht_pkg::TABLE_DEPTH];
  logic [aht_pkg::MAC_W-1:0] rd_mac_q;
  logic [aht_pkg::IP_W-1:0]  rd_ip_q;

  aht_pkg::back_state_t state_r, state_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     found_idx_r, found_idx_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  aht_pkg::cmd_t        cur_r, cur_nxt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             last_entry;
  logic             room;
  logic             adding;
  logic [CNT_W-1:0] count_fin;
  logic             same_ip;
  logic             same_mac;

  assign last_entry = ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == count_r);
  assign room       = (count_r != CNT_W'(aht_pkg::TABLE_DEPTH));
  assign adding     = cur_r.is_arp && !found_r && room;
  assign count_fin  = adding ? (count_r + CNT_W'(1)) : count_r;
  assign same_ip    = (rd_ip_q == cur_r.ip);
  assign same_mac   = (rd_mac_q == cur_r.mac);

  // Two passes over the live entries: the first finds whether the MAC is known
  // (it settles the final host count carried by every word), the second emits.
  always_comb begin
    state_nxt     = state_r;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    cmd_take      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    res_valid     = 1'b0;
    res           = '0;
    res.hosts_known = aht_pkg::HOSTS_KNOWN_W'(count_fin);
    unique case (state_r)
      aht_pkg::BK_IDLE: begin
        cmd_take = 1'b1;
        if (cmd_valid) begin
          cur_nxt       = cmd;
          found_nxt     = 1'b0;
          found_idx_nxt = '0;
          if (cmd.is_arp && (count_r != '0)) begin
            rd_en       = 1'b1;
            cmp_idx_nxt = '0;
            state_nxt   = aht_pkg::BK_FIND;
          end else begin
            state_nxt = aht_pkg::BK_CLOSE;
          end
        end
      end
      aht_pkg::BK_FIND: begin
        rd_en = 1'b1;
        if (same_mac) begin
          found_nxt = 1'b1;
        end
        if (same_mac || last_entry) begin
          cmp_idx_nxt = '0;
          state_nxt   = aht_pkg::BK_EMIT;
        end else begin
          rd_addr     = cmp_idx_r + IDX_W'(1);
          cmp_idx_nxt = rd_addr;
        end
      end
      aht_pkg::BK_EMIT: begin
        res.entry_index = aht_pkg::ENTRY_INDEX_W'(cmp_idx_r);
        res.event_mac   = cur_r.mac;
        res.event_ip    = cur_r.ip;
        if (same_ip && !same_mac) begin
          res_valid      = 1'b1;
          res.event_kind = aht_pkg::EV_CONFLICT;
          res.event_mac  = rd_mac_q;
          res.event_ip   = rd_ip_q;
        end else if (same_mac && !same_ip) begin
          res_valid      = 1'b1;
          res.event_kind = aht_pkg::EV_UPDATED;
        end
        // hold the entry while its word cannot be taken
        if (!res_valid || res_ready) begin
          if (same_mac) begin
            found_idx_nxt = cmp_idx_r;
          end
          if (same_mac && !same_ip) begin
            wr_en   = 1'b1;
            wr_addr = cmp_idx_r;
          end
          if (last_entry) begin
            state_nxt = aht_pkg::BK_CLOSE;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = cmp_idx_r + IDX_W'(1);
            cmp_idx_nxt = rd_addr;
          end
        end
      end
      aht_pkg::BK_CLOSE: begin
        res_valid      = 1'b1;
        res.event_mac  = cur_r.mac;
        res.event_ip   = cur_r.ip;
        res.last_event = 1'b1;
        if (!cur_r.is_arp) begin
          res.event_kind = aht_pkg::EV_IGNORED;
        end else if (found_r) begin
          res.event_kind  = aht_pkg::EV_KNOWN;
          res.entry_index = aht_pkg::ENTRY_INDEX_W'(found_idx_r);
        end else if (room) begin
          res.event_kind  = aht_pkg::EV_ADDED;
          res.entry_index = aht_pkg::ENTRY_INDEX_W'(count_r);
        end else begin
          res.event_kind = aht_pkg::EV_FULL;
        end
        if (res_ready) begin
          if (adding) begin
            wr_en     = 1'b1;
            wr_addr   = IDX_W'(count_r);
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = aht_pkg::BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aht_pkg::BK_IDLE;
      cmp_idx_r   <= '0;
      found_r     <= 1'b0;
      found_idx_r <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      found_r     <= found_nxt;
      found_idx_r <= found_idx_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mac_mem[wr_addr] <= cur_r.mac;
      ip_mem[wr_addr]  <= cur_r.ip;
    end
    if (rd_en) begin
      rd_mac_q <= mac_mem[rd_addr];
      rd_ip_q  <= ip_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: design/aht_out_q.sv
`default_nettype none
module aht_out_q (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  aht_pkg::out_word_t res,
  output logic               res_ready,
  output logic               empty,
  input  logic               pop,
  output aht_pkg::out_word_t out_word
);

  aht_pkg::out_word_t slot_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;
  logic               wr_en;
  logic               rd_en;

  assign res_ready = (cnt_r != 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign wr_en     = res_valid && res_ready;
  assign rd_en     = pop && !empty;
  assign out_word  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

endmodule
`default_nettype wire

FILE: design/arp_host_table_conflict_detector.sv
// Channel   Handshake              Word
// input     push / full            in_word  (frame_type, sender_mac, sender_ip)
// result    empty / pop            out_word (event_kind ... last_event)
// config    psel/penable/pwrite    arp_frame_type at paddr 0, pready tied high
//
// A non-ARP frame (or any frame while the table is empty) goes straight from idle to
// the closing word; an ARP frame otherwise walks the host table through its single
// read port, once to find the MAC (stopping at a match) and once to emit words.
// A full result queue holds the engine on the current entry; the two-word
// frame queue keeps accepting until it fills. Reset empties both queues and the
// host table (count to zero) and loads 0x0806 as the ARP ethertype.
`default_nettype none
module arp_host_table_conflict_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  aht_pkg::in_word_t              in_word,
  output logic                           empty,
  input  logic                           pop,
  output aht_pkg::out_word_t             out_word,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [aht_pkg::PADDR_W-1:0]    paddr,
  input  logic [aht_pkg::PDATA_W-1:0]    pwdata,
  output logic [aht_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  logic [aht_pkg::TYPE_W-1:0] arp_type_r;
  logic                       cfg_wr;
  logic                       cmd_valid;
  aht_pkg::cmd_t              cmd;
  logic                       cmd_take;
  logic                       res_valid;
  aht_pkg::out_word_t         res;
  logic                       res_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == aht_pkg::REG_ARP_FRAME_TYPE);
  assign prdata = (paddr == aht_pkg::REG_ARP_FRAME_TYPE) ?
                  aht_pkg::PDATA_W'(arp_type_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arp_type_r <= aht_pkg::ARP_TYPE_RESET;
    end else if (cfg_wr) begin
      arp_type_r <= pwdata[aht_pkg::TYPE_W-1:0];
    end
  end

  aht_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_word        (in_word),
    .arp_frame_type (arp_type_r),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_take       (cmd_take)
  );

  aht_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  aht_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

FILE: design/aht_checker.sv
`default_nettype none
`include "arp_host_table_conflict_detector_macros.svh"
module aht_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        empty,
  input aht_pkg::out_word_t          out_word,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [aht_pkg::PADDR_W-1:0] paddr,
  input logic [aht_pkg::PDATA_W-1:0] pwdata,
  input logic [aht_pkg::PDATA_W-1:0] prdata
);

  logic closing_kind;
  logic host_count_ok;

  assign closing_kind = (out_word.event_kind != aht_pkg::EV_CONFLICT) &&
                        (out_word.event_kind != aht_pkg::EV_UPDATED);
  assign host_count_ok = (out_word.hosts_known <= aht_pkg::HOSTS_KNOWN_W'(aht_pkg::TABLE_DEPTH));

  // nothing waits on the result side right after reset
  `AHT_ASSERT_NEXT_ALWAYS(a_empty_after_reset, clk, !rst_n, empty)
  // only the closing word of a frame carries a closing kind
  `AHT_ASSERT_IMPLY(a_last_matches_kind, clk, rst_n, !empty, out_word.last_event == closing_kind)
  // an ignored frame names no entry
  `AHT_ASSERT_IMPLY(a_ignored_no_entry, clk, rst_n, !empty && (out_word.event_kind == aht_pkg::EV_IGNORED), out_word.entry_index == '0)
  `AHT_ASSERT_IMPLY(a_host_count_range, clk, rst_n, !empty, host_count_ok)
  // a write to the type register reads back on the next cycle
  `AHT_ASSERT_NEXT(a_type_readback, clk, rst_n, psel && penable && pwrite && (paddr == aht_pkg::REG_ARP_FRAME_TYPE), (paddr != aht_pkg::REG_ARP_FRAME_TYPE) || (prdata[aht_pkg::TYPE_W-1:0] == $past(pwdata[aht_pkg::TYPE_W-1:0])))

endmodule

bind arp_host_table_conflict_detector aht_checker u_aht_checker (.*);
`default_nettype wire
